// ----- design/uer_pkg.sv -----
`timescale 1ns / 1ps

package uer_pkg;

   // Defaults for the top-level parameters.
   localparam int SETTLE_TICKS_DEF    = 2;
   localparam int TRIGGER_TICKS_DEF   = 10;
   localparam int COUNT_BITS_DEF      = 20;
   localparam int SPEED_FRAC_BITS_DEF = 24;

   // Fixed field widths.
   localparam int TEMP_W     = 11;
   localparam int MAXD_W     = 10;
   localparam int CAP_W      = 20;
   localparam int DIST_W     = 17;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 20;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DISTANCE = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_CAP  = 4'd1;

   localparam logic [MAXD_W-1:0] MAXD_RESET = 10'd400;
   localparam int DIST_MAX_CENTI = 102300;

   // Speed of sound times 1e8 in cm/us: base plus slope per tenth of a degree.
   localparam logic signed [22:0] SPEED_BASE_E8  = 23'sd3313000;
   localparam logic signed [22:0] SPEED_SLOPE_E8 = 23'sd606;

   // Divider width: holds 1e8 and twice the largest speed word.
   localparam int DEN_W = 27;
   localparam logic [DEN_W-1:0] SPEED_DIV_E8  = 27'd100000000;
   localparam logic [DEN_W-1:0] SPEED_HALF_E8 = 27'd50000000;

   // The raw wait limit always stays below 2^17 microseconds.
   localparam int LIM_W = 17;

   // Sequencer of the bit-serial divider and multiplier.
   typedef enum logic [2:0] {
      CTL_IDLE,
      CTL_SPEED,
      CTL_LIMIT,
      CTL_MUL,
      CTL_STEP
   } ctl_state_type;

   // Phase of the ranging sequence.
   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SETTLE,
      PH_TRIG,
      PH_WLOW,
      PH_WRISE,
      PH_WFALL
   } phase_type;

endpackage

// ----- design/ultrasonic_echo_ranger_top.sv -----
// Each transaction is one microsecond tick; a plain tick's result is registered from the step
// state, which waits while the result register is stalled, and the next tick is taken once the
// sequencer is idle again. Before its step state, a tick that starts a measurement takes two
// passes of the bit-serial divider (speed, then wait limit); a tick that ends one takes a pass
// of the bit-serial multiplier. One tick is in work at a time.
// Reset is synchronous and active high: phase idle, counters cleared, registers to 400 and 0.
`timescale 1ns / 1ps

module ultrasonic_echo_ranger_top
   import uer_pkg::*;
#(
   parameter int SETTLE_TICKS    = SETTLE_TICKS_DEF,
   parameter int TRIGGER_TICKS   = TRIGGER_TICKS_DEF,
   parameter int COUNT_BITS      = COUNT_BITS_DEF,
   parameter int SPEED_FRAC_BITS = SPEED_FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_start_req,
   input  logic signed [TEMP_W-1:0] req_temperature_tenths,
   input  logic                    req_echo,

   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_trigger,
   output logic                    rsp_busy_res,
   output logic                    rsp_done_res,
   output logic                    rsp_in_range,
   output logic                    rsp_timed_out,
   output logic [DIST_W-1:0]       rsp_distance_centi_cm,

   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   localparam int SPEED_W    = SPEED_FRAC_BITS - 4;
   localparam int M_W        = SPEED_W + 6;
   localparam int P_W        = M_W + COUNT_BITS;
   localparam int HI_W       = P_W - SPEED_FRAC_BITS;
   localparam int NUM_W      = SPEED_FRAC_BITS + 23;
   localparam int STEP_CNT_W = $clog2(NUM_W);
   localparam logic [32:0] COUNT_MAX_EXT = (33'd1 << COUNT_BITS) - 33'd1;

   // Configuration registers.
   logic [MAXD_W-1:0] maxd_ff, maxd_in;
   logic [CAP_W-1:0]  cap_ff, cap_in;

   // Sequencer and phase.
   ctl_state_type ctl_ff, ctl_in;
   phase_type     ph_ff, ph_in;

   logic [COUNT_BITS-1:0] tick_ff, tick_in;
   logic [COUNT_BITS-1:0] pw_ff, pw_in;
   logic [COUNT_BITS-1:0] limit_ff, limit_in;
   logic [M_W-1:0]        mcand_ff, mcand_in;
   logic                  echo_ff, echo_in;

   // Shared bit-serial divider and step counter.
   logic [NUM_W-1:0]      div_num_ff, div_num_in;
   logic [DEN_W-1:0]      div_rem_ff, div_rem_in;
   logic [DEN_W-1:0]      div_den_ff, div_den_in;
   logic [STEP_CNT_W-1:0] step_cnt_ff, step_cnt_in;

   // Bit-serial multiplier.
   logic [M_W-1:0]        mul_acc_ff, mul_acc_in;
   logic [COUNT_BITS-1:0] mul_low_ff, mul_low_in;

   // Result register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic              trig_ff, trig_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              ok_ff, ok_in;
   logic              tmo_ff, tmo_in;
   logic [DIST_W-1:0] dist_ff, dist_in;

   // Control strobes.
   logic req_take;
   logic out_free;
   logic step_fire;
   logic div_last;
   logic mul_last;
   logic load_speed;
   logic load_mul;

   // Combinational datapath values.
   logic signed [22:0]    s_e8_s;
   logic [DEN_W:0]        rem_sh;
   logic [DEN_W:0]        rem_diff;
   logic                  rem_ge;
   logic [NUM_W-1:0]      num_step;
   logic [SPEED_W-1:0]    speed_q;
   logic [M_W-1:0]        speed_x50;
   logic [12:0]           maxd_x5;
   logic [32:0]           lim_ext;
   logic [32:0]           cap_ext;
   logic [32:0]           lim_capped;
   logic [M_W:0]          mul_sum;
   logic [P_W-1:0]        p50;
   logic [HI_W-1:0]       p50_hi;
   logic [HI_W-1:0]       range_top;
   logic                  range_ok;
   logic [COUNT_BITS-1:0] tick_inc;
   logic [COUNT_BITS-1:0] tick_sat;
   logic [COUNT_BITS-1:0] pw_sat;
   logic                  wait_over;

   assign csr_ready = 1'b1;

   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step_fire = (ctl_ff == CTL_STEP) && out_free;
   assign div_last  = (step_cnt_ff == STEP_CNT_W'(NUM_W - 1));
   assign mul_last  = (step_cnt_ff == STEP_CNT_W'(COUNT_BITS - 1));

   // Which arithmetic pass a new tick needs.
   assign load_speed = req_take && (ph_ff == PH_IDLE) && req_start_req;
   assign load_mul   = req_take && (ph_ff == PH_WFALL) && !req_echo;

   // Speed of sound times 1e8 from the sampled temperature.
   assign s_e8_s = SPEED_BASE_E8 + SPEED_SLOPE_E8 * 23'(req_temperature_tenths);

   // One restoring division step.
   assign rem_sh   = {div_rem_ff, div_num_ff[NUM_W-1]};
   assign rem_diff = rem_sh - {1'b0, div_den_ff};
   assign rem_ge   = (rem_sh >= {1'b0, div_den_ff});
   assign num_step = {div_num_ff[NUM_W-2:0], rem_ge};

   // Speed quotient, never zero, and its multiple used for the distance.
   assign speed_q   = (num_step[SPEED_W-1:0] == '0) ? SPEED_W'(1) : num_step[SPEED_W-1:0];
   assign speed_x50 = M_W'({speed_q, 5'b0}) + M_W'({speed_q, 4'b0}) + M_W'({speed_q, 1'b0});
   assign maxd_x5   = 13'({maxd_ff, 2'b0}) + 13'(maxd_ff);

   // Wait limit: capped by the timeout register when that is nonzero, and saturated to the counter.
   assign lim_ext = 33'(num_step[LIM_W-1:0]);
   assign cap_ext = 33'(cap_ff);
   always_comb begin
      lim_capped = lim_ext;
      if (cap_ff != '0 && cap_ext < lim_ext) begin
         lim_capped = cap_ext;
      end
      if (lim_capped > COUNT_MAX_EXT) begin
         lim_capped = COUNT_MAX_EXT;
      end
   end

   // One shift-add multiplication step, low bits shift out into mul_low.
   assign mul_sum = {1'b0, mul_acc_ff} + (mul_low_ff[0] ? {1'b0, mcand_ff} : '0);

   // Range test on pulse_width * speed * 50 against max_distance * 100 in full precision.
   assign p50       = {mul_acc_ff, mul_low_ff};
   assign p50_hi    = p50[P_W-1:SPEED_FRAC_BITS];
   assign range_top = HI_W'(17'(maxd_ff) * 17'd100);
   assign range_ok  = (p50_hi < range_top) ||
                      ((p50_hi == range_top) && (p50[SPEED_FRAC_BITS-1:0] == '0));

   // Tick and pulse counters.
   assign tick_inc  = tick_ff + COUNT_BITS'(1);
   assign tick_sat  = (tick_ff == '1) ? tick_ff : tick_inc;
   assign pw_sat    = (pw_ff == '1) ? pw_ff : pw_ff + COUNT_BITS'(1);
   assign wait_over = (tick_sat >= limit_ff);

   // Sequencer next state.
   always_comb begin
      ctl_in = ctl_ff;
      case (ctl_ff)
         CTL_IDLE: begin
            if (load_speed) begin
               ctl_in = CTL_SPEED;
            end else if (load_mul) begin
               ctl_in = CTL_MUL;
            end else if (req_take) begin
               ctl_in = CTL_STEP;
            end
         end
         CTL_SPEED: begin
            if (div_last) begin
               ctl_in = CTL_LIMIT;
            end
         end
         CTL_LIMIT: begin
            if (div_last) begin
               ctl_in = CTL_STEP;
            end
         end
         CTL_MUL: begin
            if (mul_last) begin
               ctl_in = CTL_STEP;
            end
         end
         CTL_STEP: begin
            if (out_free) begin
               ctl_in = CTL_IDLE;
            end
         end
         default: begin
            ctl_in = CTL_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_stall = 1'b1;
      case (ctl_ff)
         CTL_IDLE: begin
            req_stall = 1'b0;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // Arithmetic units: loads, steps and captured results.
   always_comb begin
      div_num_in  = div_num_ff;
      div_rem_in  = div_rem_ff;
      div_den_in  = div_den_ff;
      step_cnt_in = step_cnt_ff;
      mul_acc_in  = mul_acc_ff;
      mul_low_in  = mul_low_ff;
      mcand_in    = mcand_ff;
      limit_in    = limit_ff;
      echo_in     = echo_ff;

      if (req_take) begin
         echo_in = req_echo;
      end

      if (load_speed) begin
         div_num_in  = NUM_W'({s_e8_s[21:0], {SPEED_FRAC_BITS{1'b0}}}) + NUM_W'(SPEED_HALF_E8);
         div_rem_in  = '0;
         div_den_in  = SPEED_DIV_E8;
         step_cnt_in = '0;
      end else if (load_mul) begin
         mul_acc_in  = '0;
         mul_low_in  = pw_ff;
         step_cnt_in = '0;
      end

      case (ctl_ff)
         CTL_SPEED: begin
            if (div_last) begin
               mcand_in    = speed_x50;
               div_num_in  = NUM_W'({maxd_x5, {SPEED_FRAC_BITS{1'b0}}});
               div_rem_in  = '0;
               div_den_in  = DEN_W'({speed_q, 1'b0});
               step_cnt_in = '0;
            end else begin
               div_num_in  = num_step;
               div_rem_in  = rem_ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
               step_cnt_in = step_cnt_ff + STEP_CNT_W'(1);
            end
         end
         CTL_LIMIT: begin
            div_num_in  = num_step;
            div_rem_in  = rem_ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            step_cnt_in = step_cnt_ff + STEP_CNT_W'(1);
            if (div_last) begin
               limit_in = lim_capped[COUNT_BITS-1:0];
            end
         end
         CTL_MUL: begin
            mul_acc_in  = mul_sum[M_W:1];
            mul_low_in  = {mul_sum[0], mul_low_ff[COUNT_BITS-1:1]};
            step_cnt_in = step_cnt_ff + STEP_CNT_W'(1);
         end
         default: begin
         end
      endcase
   end

   // Phase next state.
   always_comb begin
      ph_in   = ph_ff;
      tick_in = tick_ff;
      pw_in   = pw_ff;
      if (ctl_ff == CTL_LIMIT && div_last) begin
         ph_in   = PH_SETTLE;
         tick_in = '0;
         pw_in   = '0;
      end else if (step_fire) begin
         case (ph_ff)
            PH_IDLE: begin
            end
            PH_SETTLE: begin
               if (tick_inc >= COUNT_BITS'(SETTLE_TICKS)) begin
                  ph_in   = PH_TRIG;
                  tick_in = '0;
               end else begin
                  tick_in = tick_inc;
               end
            end
            PH_TRIG: begin
               if (tick_inc >= COUNT_BITS'(TRIGGER_TICKS)) begin
                  ph_in   = PH_WLOW;
                  tick_in = '0;
               end else begin
                  tick_in = tick_inc;
               end
            end
            PH_WLOW: begin
               tick_in = tick_sat;
               if (wait_over) begin
                  ph_in = PH_IDLE;
               end else if (!echo_ff) begin
                  ph_in = PH_WRISE;
               end
            end
            PH_WRISE: begin
               tick_in = tick_sat;
               if (echo_ff) begin
                  pw_in = COUNT_BITS'(1);
               end
               if (wait_over) begin
                  ph_in = PH_IDLE;
               end else if (echo_ff) begin
                  ph_in = PH_WFALL;
               end
            end
            PH_WFALL: begin
               if (echo_ff) begin
                  pw_in   = pw_sat;
                  tick_in = tick_sat;
                  if (wait_over) begin
                     ph_in = PH_IDLE;
                  end
               end else begin
                  ph_in = PH_IDLE;
               end
            end
            default: begin
               ph_in = PH_IDLE;
            end
         endcase
      end
   end

   // Phase outputs: the result of the tick.
   always_comb begin
      trig_in = 1'b0;
      done_in = 1'b0;
      ok_in   = 1'b0;
      tmo_in  = 1'b0;
      dist_in = '0;
      busy_in = (ph_in != PH_IDLE);
      case (ph_ff)
         PH_TRIG: begin
            trig_in = 1'b1;
         end
         PH_WLOW, PH_WRISE: begin
            done_in = wait_over;
            tmo_in  = wait_over;
         end
         PH_WFALL: begin
            if (echo_ff) begin
               done_in = wait_over;
               tmo_in  = wait_over;
            end else begin
               done_in = 1'b1;
               ok_in   = range_ok;
               dist_in = range_ok ? p50_hi[DIST_W-1:0] : '0;
            end
         end
         default: begin
         end
      endcase
   end

   // Result register valid.
   always_comb begin
      if (step_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Configuration writes.
   always_comb begin
      maxd_in = maxd_ff;
      cap_in  = cap_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MAX_DISTANCE: maxd_in = csr_wdata[MAXD_W-1:0];
            CSR_TIMEOUT_CAP:  cap_in  = csr_wdata[CAP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff       <= CTL_IDLE;
         ph_ff        <= PH_IDLE;
         tick_ff      <= '0;
         pw_ff        <= '0;
         limit_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         maxd_ff      <= MAXD_RESET;
         cap_ff       <= '0;
      end else begin
         ctl_ff       <= ctl_in;
         ph_ff        <= ph_in;
         tick_ff      <= tick_in;
         pw_ff        <= pw_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
         maxd_ff      <= maxd_in;
         cap_ff       <= cap_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      echo_ff     <= echo_in;
      mcand_ff    <= mcand_in;
      div_num_ff  <= div_num_in;
      div_rem_ff  <= div_rem_in;
      div_den_ff  <= div_den_in;
      step_cnt_ff <= step_cnt_in;
      mul_acc_ff  <= mul_acc_in;
      mul_low_ff  <= mul_low_in;
   end

   // Result payload, loaded when a tick completes.
   always_ff @(posedge clock) begin
      if (step_fire) begin
         trig_ff <= trig_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
         ok_ff   <= ok_in;
         tmo_ff  <= tmo_in;
         dist_ff <= dist_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_trigger           = trig_ff;
   assign rsp_busy_res          = busy_ff;
   assign rsp_done_res          = done_ff;
   assign rsp_in_range          = ok_ff;
   assign rsp_timed_out         = tmo_ff;
   assign rsp_distance_centi_cm = dist_ff;

endmodule

// ----- design/uer_checker.sv -----
`timescale 1ns / 1ps

module uer_checker
   import uer_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic              rsp_trigger,
   input logic              rsp_busy_res,
   input logic              rsp_done_res,
   input logic              rsp_in_range,
   input logic              rsp_timed_out,
   input logic [DIST_W-1:0] rsp_distance_centi_cm
);

   // A stalled result transaction keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_distance_centi_cm)
         && $stable(rsp_done_res) && $stable(rsp_in_range) && $stable(rsp_timed_out))
      else $error("result payload changed while stalled");

   // Status flags only appear on the tick that finishes a measurement.
   a_flags_with_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |-> !rsp_in_range && !rsp_timed_out
         && rsp_distance_centi_cm == '0)
      else $error("status flags without done");

   // A valid distance is never a timeout and stays within the range limit.
   a_range_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_in_range |-> !rsp_timed_out
         && rsp_distance_centi_cm <= DIST_W'(DIST_MAX_CENTI))
      else $error("in-range result is inconsistent");

   // A finished measurement leaves the block idle.
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res)
      else $error("busy on the finishing tick");

   // The trigger pulse belongs to a running sequence.
   a_trigger_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_trigger |-> rsp_busy_res && !rsp_done_res)
      else $error("trigger outside a measurement");

endmodule

bind ultrasonic_echo_ranger_top uer_checker u_uer_checker (.*);
